// ===== design/match_entry_pool_list_manager_macros.svh =====
// Assertion macros for the block's RTL, included by match_entry_pool_list_manager.sv.
`ifndef MATCH_ENTRY_POOL_LIST_MANAGER_MACROS_SVH
`define MATCH_ENTRY_POOL_LIST_MANAGER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define MEPL_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mepl: implication check failed");
// Next-cycle implication.
`define MEPL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mepl: next-cycle check failed");
`else
`define MEPL_ASSERT_IMP(name, clk, rst, ante, cons)
`define MEPL_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== design/mepl_pkg.sv =====
package mepl_pkg;

   localparam int NI_W          = 2;
   localparam int PORTAL_W      = 6;
   localparam int KIND_W        = 2;
   localparam int INDEX_W       = 8;
   localparam int STATUS_W      = 3;
   localparam int IFACE_EN_W    = 4;
   localparam int ENTRY_LIMIT_W = 9;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 9;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 3'd0,
      STAT_FULL        = 3'd1,
      STAT_INVALID     = 3'd2,
      STAT_UNSUPPORTED = 3'd3,
      STAT_NOT_QUEUED  = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INITIALIZED = 2'd0,
      CSR_IFACE_EN    = 2'd1,
      CSR_LAST_PORTAL = 2'd2,
      CSR_ENTRY_LIMIT = 2'd3
   } csr_index_type;

   localparam logic ACT_APPEND = 1'b0;
   localparam logic ACT_UNLINK = 1'b1;

   localparam logic [KIND_W-1:0] KIND_PRIORITY = 2'd0;
   localparam logic              LIST_OVERFLOW = 1'b1;
   localparam logic              LIST_PRIORITY = 1'b0;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_OVQ_CHK,
      S_TGQ_CHK,
      S_LINK,
      S_TAIL_CHK,
      S_LINK_WR,
      S_UL_CHK,
      S_ULQ_CHK,
      S_WALK_RD,
      S_WALK_CHK,
      S_FREE_WR,
      S_RESULT
   } state_type;

endpackage

// ===== design/mepl_ifs.sv =====
interface mepl_req_if
   import mepl_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                action;
   logic [NI_W-1:0]     interface_req;
   logic [PORTAL_W-1:0] portal_index;
   logic [KIND_W-1:0]   list_kind;
   logic                portal_valid;
   logic [INDEX_W-1:0]  entry_index;

   modport source (output valid, action, interface_req, portal_index, list_kind,
                   portal_valid, entry_index, input ready);
   modport sink   (input valid, action, interface_req, portal_index, list_kind,
                   portal_valid, entry_index, output ready);
endinterface

interface mepl_rsp_if
   import mepl_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  allocated_index;

   modport source (output valid, status, allocated_index, input ready);
   modport sink   (input valid, status, allocated_index, output ready);
endinterface

// ===== design/match_entry_pool_list_manager.sv =====
// Channel   Dir  Payload                                                  Handshake
// req_ch    in   action, interface_req, portal_index, list_kind,          valid/ready
//                portal_valid, entry_index
// rsp_ch    out  status, allocated_index                                  valid/ready
// csr_*     in   csr_index, csr_wdata                                     csr_we, no stall
//
// One item at a time. Append: the accept, a check state, a read and a check state per pool
// slot scanned up to and including the first free one, the queue reads and the tail link,
// and the load of the output register.
// Successful unlink: accept, check, slot read, queue read, a read and a check state per
// queue entry walked up to and including the target, the free write and the result load.
// The slot memory has a single registered read port, so each read has its own state.
// After reset a clearing pass writes every slot and queue word before req_ch.ready.
// A finished result waits in the output register; the next item is taken meanwhile.
`include "match_entry_pool_list_manager_macros.svh"

module match_entry_pool_list_manager
   import mepl_pkg::*;
   #(parameter int NUM_INTERFACES = 4,
     parameter int POOL_SLOTS     = 256,
     parameter int PORTAL_ENTRIES = 64)
   (input  logic                  clock,
    input  logic                  reset,
    mepl_req_if.sink              req_ch,
    mepl_rsp_if.source            rsp_ch,
    input  logic                  csr_we,
    input  logic [CSR_IDX_W-1:0]  csr_index,
    input  logic [CSR_DATA_W-1:0] csr_wdata);

   localparam int SIW    = $clog2(POOL_SLOTS + 1);
   localparam int SDEPTH = NUM_INTERFACES * POOL_SLOTS;
   localparam int SAW    = $clog2(SDEPTH);
   localparam int QDEPTH = NUM_INTERFACES * PORTAL_ENTRIES * 2;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int CDEPTH = (SDEPTH > QDEPTH) ? SDEPTH : QDEPTH;
   localparam int CW     = $clog2(CDEPTH);
   localparam int LW     = (SIW > ENTRY_LIMIT_W) ? SIW : ENTRY_LIMIT_W;
   localparam logic [SIW-1:0] NIL = SIW'(POOL_SLOTS);

   typedef struct packed {
      logic                alloc;
      logic [PORTAL_W-1:0] portal;
      logic                list;
      logic [SIW-1:0]      next;
   } slot_word_type;

   typedef struct packed {
      logic [SIW-1:0] head;
      logic [SIW-1:0] tail;
   } queue_word_type;

   localparam int SWW = $bits(slot_word_type);
   localparam int QWW = $bits(queue_word_type);

   function automatic logic [SAW-1:0] slot_addr(input logic [NI_W-1:0] ni,
                                                input logic [SIW-1:0] s);
      slot_addr = SAW'(ni) * SAW'(POOL_SLOTS) + SAW'(s);
   endfunction

   function automatic logic [QAW-1:0] queue_addr(input logic [NI_W-1:0]     ni,
                                                 input logic [PORTAL_W-1:0] pt,
                                                 input logic                lst);
      logic [QAW-1:0] x;
      x = QAW'(ni) * QAW'(PORTAL_ENTRIES) + QAW'(pt);
      queue_addr = QAW'(x << 1) | QAW'(lst);
   endfunction

   // memories
   logic           slot_we, queue_we;
   logic [SAW-1:0] slot_waddr, slot_raddr;
   logic [QAW-1:0] queue_waddr, queue_raddr;
   slot_word_type  slot_wdata, slot_rd;
   queue_word_type queue_wdata, queue_rd;
   logic [SWW-1:0] slot_rdata;
   logic [QWW-1:0] queue_rdata;

   mepl_ram #(.WIDTH(SWW), .DEPTH(SDEPTH)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_rdata));

   mepl_ram #(.WIDTH(QWW), .DEPTH(QDEPTH)) u_queue_ram (
      .clock (clock),
      .we    (queue_we),
      .waddr (queue_waddr),
      .wdata (queue_wdata),
      .raddr (queue_raddr),
      .rdata (queue_rdata));

   assign slot_rd  = slot_word_type'(slot_rdata);
   assign queue_rd = queue_word_type'(queue_rdata);

   // registers
   state_type                  state_ff, state_in;
   logic [CW-1:0]              clr_ff, clr_in;
   logic                       init_ff, init_in;
   logic [IFACE_EN_W-1:0]      iface_en_ff, iface_en_in;
   logic [PORTAL_W-1:0]        last_pt_ff, last_pt_in;
   logic [ENTRY_LIMIT_W-1:0]   limit_ff, limit_in;
   logic                       act_ff, act_in;
   logic [NI_W-1:0]            ni_ff, ni_in;
   logic [PORTAL_W-1:0]        pt_ff, pt_in;
   logic [KIND_W-1:0]          kind_ff, kind_in;
   logic                       pv_ff, pv_in;
   logic [INDEX_W-1:0]         code_ff, code_in;
   logic [SIW-1:0]             scan_ff, scan_in;
   logic [SIW-1:0]             new_ff, new_in;
   queue_word_type             q_ff, q_in;
   logic [SIW-1:0]             cur_ff, cur_in;
   logic [SIW-1:0]             prev_ff, prev_in;
   logic [SIW-1:0]             steps_ff, steps_in;
   slot_word_type              prev_word_ff, prev_word_in;
   slot_word_type              hit_ff, hit_in;
   logic [PORTAL_W-1:0]        ul_pt_ff, ul_pt_in;
   logic                       ul_list_ff, ul_list_in;
   status_type                 res_status_ff, res_status_in;
   logic [INDEX_W-1:0]         res_index_ff, res_index_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 status_ff, status_in;
   logic [INDEX_W-1:0]         index_ff, index_in;

   logic [LW-1:0] lim;
   logic          iface_ok, append_bad, unlink_bad;
   slot_word_type new_word;

   // configuration writes
   always_comb begin
      init_in     = init_ff;
      iface_en_in = iface_en_ff;
      last_pt_in  = last_pt_ff;
      limit_in    = limit_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_INITIALIZED: init_in     = csr_wdata[0];
            CSR_IFACE_EN:    iface_en_in = csr_wdata[IFACE_EN_W-1:0];
            CSR_LAST_PORTAL: last_pt_in  = csr_wdata[PORTAL_W-1:0];
            CSR_ENTRY_LIMIT: limit_in    = csr_wdata[ENTRY_LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      lim = (LW'(limit_ff) > LW'(POOL_SLOTS)) ? LW'(POOL_SLOTS) : LW'(limit_ff);
      iface_ok = (ni_ff < NI_W'(NUM_INTERFACES) || NUM_INTERFACES > 3)
                 && iface_en_ff[ni_ff];
      append_bad = !init_ff || !iface_ok || ni_ff[0] || (pt_ff > last_pt_ff)
                   || (11'(pt_ff) >= 11'(PORTAL_ENTRIES)) || !pv_ff;
      unlink_bad = !init_ff || !iface_ok || (LW'(code_ff) >= lim);
      new_word = '{alloc: 1'b1, portal: pt_ff, list: kind_ff[0], next: NIL};
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      act_in        = act_ff;
      ni_in         = ni_ff;
      pt_in         = pt_ff;
      kind_in       = kind_ff;
      pv_in         = pv_ff;
      code_in       = code_ff;
      scan_in       = scan_ff;
      new_in        = new_ff;
      q_in          = q_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      prev_word_in  = prev_word_ff;
      hit_in        = hit_ff;
      ul_pt_in      = ul_pt_ff;
      ul_list_in    = ul_list_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff;
      status_in     = status_ff;
      index_in      = index_ff;
      slot_we       = 1'b0;
      slot_waddr    = '0;
      slot_wdata    = '0;
      slot_raddr    = '0;
      queue_we      = 1'b0;
      queue_waddr   = '0;
      queue_wdata   = '0;
      queue_raddr   = '0;
      req_ch.ready  = 1'b0;

      // drop a delivered item
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            slot_we     = (CW + 1)'(clr_ff) < (CW + 1)'(SDEPTH);
            slot_waddr  = SAW'(clr_ff);
            slot_wdata  = '0;
            queue_we    = (CW + 1)'(clr_ff) < (CW + 1)'(QDEPTH);
            queue_waddr = QAW'(clr_ff);
            queue_wdata = '{head: NIL, tail: NIL};
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == CW'(CDEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               act_in   = req_ch.action;
               ni_in    = req_ch.interface_req;
               pt_in    = req_ch.portal_index;
               kind_in  = req_ch.list_kind;
               pv_in    = req_ch.portal_valid;
               code_in  = req_ch.entry_index;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            res_index_in = '0;
            if (act_ff == ACT_UNLINK) begin
               if (unlink_bad) begin
                  res_status_in = STAT_INVALID;
                  state_in      = S_RESULT;
               end else begin
                  slot_raddr = slot_addr(ni_ff, SIW'(code_ff));
                  state_in   = S_UL_CHK;
               end
            end else if (append_bad) begin
               res_status_in = STAT_INVALID;
               state_in      = S_RESULT;
            end else begin
               scan_in  = '0;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (LW'(scan_ff) >= lim) begin
               res_status_in = STAT_FULL;
               state_in      = S_RESULT;
            end else begin
               slot_raddr = slot_addr(ni_ff, scan_ff);
               state_in   = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (!slot_rd.alloc) begin
               new_in = scan_ff;
               if (kind_ff[1]) begin
                  res_status_in = STAT_UNSUPPORTED;
                  state_in      = S_RESULT;
               end else begin
                  queue_raddr = queue_addr(ni_ff, pt_ff, LIST_OVERFLOW);
                  state_in    = S_OVQ_CHK;
               end
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_OVQ_CHK: begin
            if (kind_ff == KIND_PRIORITY) begin
               // priority append is refused while overflow holds entries
               if (queue_rd.head != NIL) begin
                  res_status_in = STAT_UNSUPPORTED;
                  state_in      = S_RESULT;
               end else begin
                  queue_raddr = queue_addr(ni_ff, pt_ff, LIST_PRIORITY);
                  state_in    = S_TGQ_CHK;
               end
            end else begin
               q_in     = queue_rd;
               state_in = S_LINK;
            end
         end
         S_TGQ_CHK: begin
            q_in     = queue_rd;
            state_in = S_LINK;
         end
         S_LINK: begin
            if (LW'(q_ff.tail) >= LW'(POOL_SLOTS)) begin
               slot_we       = 1'b1;
               slot_waddr    = slot_addr(ni_ff, new_ff);
               slot_wdata    = new_word;
               queue_we      = 1'b1;
               queue_waddr   = queue_addr(ni_ff, pt_ff, kind_ff[0]);
               queue_wdata   = '{head: new_ff, tail: new_ff};
               res_status_in = STAT_OK;
               res_index_in  = INDEX_W'(new_ff);
               state_in      = S_RESULT;
            end else begin
               slot_raddr = slot_addr(ni_ff, q_ff.tail);
               state_in   = S_TAIL_CHK;
            end
         end
         S_TAIL_CHK: begin
            slot_we         = 1'b1;
            slot_waddr      = slot_addr(ni_ff, q_ff.tail);
            slot_wdata      = slot_rd;
            slot_wdata.next = new_ff;
            queue_we        = 1'b1;
            queue_waddr     = queue_addr(ni_ff, pt_ff, kind_ff[0]);
            queue_wdata     = '{head: q_ff.head, tail: new_ff};
            state_in        = S_LINK_WR;
         end
         S_LINK_WR: begin
            slot_we       = 1'b1;
            slot_waddr    = slot_addr(ni_ff, new_ff);
            slot_wdata    = new_word;
            res_status_in = STAT_OK;
            res_index_in  = INDEX_W'(new_ff);
            state_in      = S_RESULT;
         end
         S_UL_CHK: begin
            if (!slot_rd.alloc) begin
               res_status_in = STAT_INVALID;
               state_in      = S_RESULT;
            end else begin
               ul_pt_in    = slot_rd.portal;
               ul_list_in  = slot_rd.list;
               queue_raddr = queue_addr(ni_ff, slot_rd.portal, slot_rd.list);
               state_in    = S_ULQ_CHK;
            end
         end
         S_ULQ_CHK: begin
            q_in     = queue_rd;
            cur_in   = queue_rd.head;
            prev_in  = NIL;
            steps_in = '0;
            state_in = S_WALK_RD;
         end
         S_WALK_RD: begin
            if (LW'(cur_ff) >= LW'(POOL_SLOTS) || steps_ff >= NIL) begin
               res_status_in = STAT_NOT_QUEUED;
               state_in      = S_RESULT;
            end else begin
               slot_raddr = slot_addr(ni_ff, cur_ff);
               state_in   = S_WALK_CHK;
            end
         end
         S_WALK_CHK: begin
            if (LW'(cur_ff) == LW'(code_ff)) begin
               hit_in      = slot_rd;
               queue_we    = 1'b1;
               queue_waddr = queue_addr(ni_ff, ul_pt_ff, ul_list_ff);
               queue_wdata.head = (prev_ff == NIL) ? slot_rd.next : q_ff.head;
               queue_wdata.tail = (LW'(slot_rd.next) >= LW'(POOL_SLOTS)) ? prev_ff
                                                                          : q_ff.tail;
               if (prev_ff != NIL) begin
                  slot_we         = 1'b1;
                  slot_waddr      = slot_addr(ni_ff, prev_ff);
                  slot_wdata      = prev_word_ff;
                  slot_wdata.next = slot_rd.next;
               end
               state_in = S_FREE_WR;
            end else begin
               prev_in      = cur_ff;
               prev_word_in = slot_rd;
               cur_in       = slot_rd.next;
               steps_in     = steps_ff + 1'b1;
               state_in     = S_WALK_RD;
            end
         end
         S_FREE_WR: begin
            slot_we          = 1'b1;
            slot_waddr       = slot_addr(ni_ff, cur_ff);
            slot_wdata       = hit_ff;
            slot_wdata.alloc = 1'b0;
            res_status_in    = STAT_OK;
            state_in         = S_RESULT;
         end
         S_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               status_in    = res_status_ff;
               index_in     = res_index_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         init_ff      <= 1'b0;
         iface_en_ff  <= '0;
         last_pt_ff   <= '1;
         limit_ff     <= ENTRY_LIMIT_W'(256);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         init_ff      <= init_in;
         iface_en_ff  <= iface_en_in;
         last_pt_ff   <= last_pt_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      ni_ff         <= ni_in;
      pt_ff         <= pt_in;
      kind_ff       <= kind_in;
      pv_ff         <= pv_in;
      code_ff       <= code_in;
      scan_ff       <= scan_in;
      new_ff        <= new_in;
      q_ff          <= q_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      prev_word_ff  <= prev_word_in;
      hit_ff        <= hit_in;
      ul_pt_ff      <= ul_pt_in;
      ul_list_ff    <= ul_list_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      status_ff     <= status_in;
      index_ff      <= index_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = status_ff;
   assign rsp_ch.allocated_index = index_ff;

   `MEPL_ASSERT_NEXT(a_accept_starts_work, clock, reset, req_ch.valid && req_ch.ready, state_ff == S_CHECK)
   `MEPL_ASSERT_IMP(a_idle_no_writes, clock, reset, state_ff == S_IDLE, !slot_we && !queue_we)
   `MEPL_ASSERT_IMP(a_index_only_on_ok, clock, reset, rsp_valid_ff && status_ff != STAT_OK, index_ff == '0)

endmodule

// ===== design/mepl_ram.sv =====
module mepl_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 256)
   (input  logic                     clock,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
